>>> rtl/packed_date_time_clock_unit_macros.svh
// ----------------------------------------------------------------------------
// Packed date/time clock assertion macros
// Concurrent check shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_DATE_TIME_CLOCK_UNIT_MACROS_SVH
`define PACKED_DATE_TIME_CLOCK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PDTC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdtc same-cycle check failed");
`define PDTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdtc next-cycle check failed");
`else
`define PDTC_ASSERT_SAME(lbl, ante, cons)
`define PDTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/pdtc_pkg.sv
// ----------------------------------------------------------------------------
// Packed date/time clock package
// Shared widths, calendar constants, command word and month length table.
// ----------------------------------------------------------------------------
package pdtc_pkg;

    localparam int VALUE_W         = 16;
    localparam int ACC_W           = 11;
    localparam int SUM_W           = VALUE_W + 1;
    localparam int MS_PER_STEP_DEF = 2000;
    localparam int Q_DEPTH         = 2;

    localparam logic [6:0] YEAR_MAX   = 7'd119;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [4:0] DAY_FEB_LY = 5'd29;
    localparam logic [4:0] DAY_SAFE   = 5'd28;
    localparam logic [4:0] DAY_LAST   = 5'd31;
    localparam logic [4:0] SEC2_LIMIT = 5'd30;
    localparam logic [5:0] MIN_LIMIT  = 6'd60;
    localparam logic [4:0] HOUR_LIMIT = 5'd24;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_DATE = 2'd1,
        OP_SET_TIME = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic               ok;
    } cmd_t;

    function automatic logic [4:0] month_len(input logic [3:0] mo);
        logic [4:0] len;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/packed_date_time_clock_unit.sv
// ----------------------------------------------------------------------------
// Packed date/time clock unit
// Calendar clock on packed date and time words with a millisecond tick.
//
//   Channel  Handshake             Word
//   input    in_valid / in_ready   operation, value
//   output   out_valid / out_ready status, date_now, time_now
//
// One word per cycle sustained unless the output stalls; an accepted word
// goes through the queue write, then the back end's result register.
// The back end's combinational carry cascade over the state sets the rate.
// Reset clears time, date, millisecond count, queue and output valid.
// A stalled output holds the back end; the queue keeps taking words until
// it is full, then in_ready drops.
// ----------------------------------------------------------------------------
`include "packed_date_time_clock_unit_macros.svh"

module packed_date_time_clock_unit
    import pdtc_pkg::*;
#(
    parameter int MS_PER_STEP = MS_PER_STEP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         operation,
    input  logic [VALUE_W-1:0] value,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               status,
    output logic [VALUE_W-1:0] date_now,
    output logic [VALUE_W-1:0] time_now,
    output logic               out_valid,
    input  logic               out_ready
);

    logic q_full;
    logic q_push;
    cmd_t q_in_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    pdtc_front u_front (
        .operation (operation),
        .value     (value),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in_cmd)
    );

    pdtc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    pdtc_back #(
        .MS_PER_STEP (MS_PER_STEP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .status    (status),
        .date_now  (date_now),
        .time_now  (time_now),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    `PDTC_ASSERT_NEXT(a_push_lands, in_valid && in_ready, q_valid)
    `PDTC_ASSERT_SAME(a_full_not_empty, !in_ready, q_valid)
    `PDTC_ASSERT_SAME(a_time_in_range, out_valid, (time_now[4:0] < SEC2_LIMIT) && (time_now[10:5] < MIN_LIMIT) && (time_now[15:11] < HOUR_LIMIT))
    `PDTC_ASSERT_SAME(a_month_in_range, out_valid, date_now[8:5] <= MONTH_MAX)

endmodule

>>> rtl/pdtc_front.sv
// ----------------------------------------------------------------------------
// Packed date/time clock front end
// Accepts input words, decodes the operation and checks set-date and
// set-time words before they enter the command queue.
// ----------------------------------------------------------------------------
module pdtc_front
    import pdtc_pkg::*;
(
    input  logic [1:0]         operation,
    input  logic [VALUE_W-1:0] value,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    logic [6:0] year;
    logic [3:0] mo;
    logic [4:0] day;
    logic       date_ok;
    logic       time_ok;

    assign year = value[15:9];
    assign mo   = value[8:5];
    assign day  = value[4:0];

    always_comb
    begin
        date_ok = 1'b0;
        if ((year <= YEAR_MAX) && (mo <= MONTH_MAX))
        begin
            if ((mo == MONTH_FEB) && (value[10:9] == 2'd0))
                date_ok = (day <= DAY_FEB_LY);
            else
                date_ok = (day <= month_len(mo));
        end
    end

    assign time_ok = (value[4:0] < SEC2_LIMIT) && (value[10:5] < MIN_LIMIT)
                     && (value[15:11] < HOUR_LIMIT);

    always_comb
    begin
        q_cmd.op    = op_t'(operation);
        q_cmd.value = value;
        unique case (op_t'(operation))
            OP_SET_DATE: q_cmd.ok = date_ok;
            OP_SET_TIME: q_cmd.ok = time_ok;
            OP_TICK,
            OP_READ:     q_cmd.ok = 1'b1;
            default:     q_cmd.ok = 1'b1;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

endmodule

>>> rtl/pdtc_queue.sv
// ----------------------------------------------------------------------------
// Packed date/time clock command queue
// Short FIFO between front end and back end; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pdtc_queue
    import pdtc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    cmd_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> rtl/pdtc_back.sv
// ----------------------------------------------------------------------------
// Packed date/time clock back end
// Holds the time, date and millisecond state, executes one queued command
// per cycle unless the output stalls; results sit in an output register.
// ----------------------------------------------------------------------------
module pdtc_back
    import pdtc_pkg::*;
#(
    parameter int MS_PER_STEP = MS_PER_STEP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               status,
    output logic [VALUE_W-1:0] date_now,
    output logic [VALUE_W-1:0] time_now,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam logic [SUM_W-1:0] STEP_SUM  = SUM_W'(MS_PER_STEP);
    localparam logic [ACC_W-1:0] ACC_SATUR = ACC_W'(MS_PER_STEP - 1);

    logic [VALUE_W-1:0] time_reg, time_next;
    logic [VALUE_W-1:0] date_reg, date_next;
    logic [ACC_W-1:0]   accum_reg, accum_next;
    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;

    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   sum_left;

    function automatic logic [VALUE_W-1:0] next_month(input logic [VALUE_W-1:0] d);
        logic [VALUE_W-1:0] m1;
        m1 = (d & 16'hFFE0) + 16'h0021;
        if (m1[8:5] <= MONTH_MAX)
            return m1;
        return (m1 & 16'hFE00) + 16'h0221;
    endfunction

    function automatic logic [VALUE_W-1:0] next_day(input logic [VALUE_W-1:0] d);
        logic [VALUE_W-1:0] d1;
        logic [4:0]         dy;
        logic [3:0]         m;
        logic [VALUE_W-1:0] r;
        d1 = d + 16'd1;
        dy = d1[4:0];
        m  = d1[8:5];
        if (d[4:0] == DAY_LAST)
            r = next_month(d);
        else if (dy <= DAY_SAFE)
            r = d1;
        else if ((m == MONTH_FEB) && (d1[10:9] == 2'd0))
            r = (dy <= DAY_FEB_LY) ? d1 : next_month(d1);
        else
            r = (dy <= month_len(m)) ? d1 : next_month(d1);
        return r;
    endfunction

    always_comb
    begin
        logic [VALUE_W-1:0] t1;
        logic [VALUE_W-1:0] t2;
        logic [VALUE_W-1:0] t3;

        q_pop          = q_valid && (!out_valid_reg || out_ready);
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (q_pop)
            out_valid_next = 1'b1;

        time_next   = time_reg;
        date_next   = date_reg;
        accum_next  = accum_reg;
        status_next = status_reg;

        sum      = {{(SUM_W - ACC_W){1'b0}}, accum_reg} + {1'b0, q_cmd.value};
        sum_left = sum - STEP_SUM;

        t1 = time_reg + 16'd1;
        t2 = (t1 & 16'hFFE0) + 16'h0020;
        t3 = (t2 & 16'hF81F) + 16'h0800;

        if (q_pop)
        begin
            status_next = 1'b0;
            unique case (q_cmd.op)
                OP_TICK:
                begin
                    if (sum >= STEP_SUM)
                    begin
                        accum_next = (sum_left >= STEP_SUM) ? ACC_SATUR
                                                            : sum_left[ACC_W-1:0];
                        if (t1[4:0] != SEC2_LIMIT)
                            time_next = t1;
                        else if (t2[10:5] != MIN_LIMIT)
                            time_next = t2;
                        else if (t3[15:11] != HOUR_LIMIT)
                            time_next = t3;
                        else
                        begin
                            time_next = '0;
                            date_next = next_day(date_reg);
                        end
                    end
                    else
                        accum_next = sum[ACC_W-1:0];
                end
                OP_SET_DATE:
                begin
                    if (q_cmd.ok)
                        date_next = q_cmd.value;
                    else
                        status_next = 1'b1;
                end
                OP_SET_TIME:
                begin
                    if (q_cmd.ok)
                        time_next = q_cmd.value;
                    else
                        status_next = 1'b1;
                end
                OP_READ:
                begin
                    status_next = 1'b0;
                end
                default:
                begin
                    status_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            date_reg      <= '0;
            accum_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            time_reg      <= time_next;
            date_reg      <= date_next;
            accum_reg     <= accum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign date_now  = date_reg;
    assign time_now  = time_reg;

endmodule
